### src/hlr_pkg.sv
// ----------------------------------------------------------------------------
// hlr_pkg: shared constants of the hex line rasterizer
// Port widths of the item fields and the default coordinate width.
// ----------------------------------------------------------------------------
`default_nettype none

package hlr_pkg;

  // input coordinate ports, two's complement
  localparam int IN_W = 5;
  // output coordinate ports, two's complement
  localparam int OUT_W = 6;
  // step index port, unsigned
  localparam int IDX_W = 6;
  // default number of coordinate bits used from each input port
  localparam int COORD_BITS_DEF = 5;

endpackage

`default_nettype wire

### src/hex_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// hex_line_rasterizer_top: hex grid line drawing with cube rounding
// Takes two axial hexes and emits every hex of the line between them.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one item carries start and end hex in
//   axial coordinates. Only the low COORD_BITS bits of each field are used,
//   sign-extended. in_stall is high while a line is being drawn.
//   Result channel (out_valid / out_stall): N+1 items per input item, N the
//   hex distance, each with hex_q, hex_r, step_index and is_last (set on the
//   end hex). A zero-length line gives the start hex alone.
//   Timing: the distance is measured in the cycle after the accepting edge,
//   the shared multiplier sets up the three cube components one at a time
//   and one rounding check follows before the first hex is shown in the
//   output register. Each further hex takes one add and one or more rounding
//   checks per component through the shared error adder before it is loaded
//   into the output register. A new item is taken only after the last hex of
//   the line has left the output register.
//   The fraction is tracked exactly: each component keeps its rounded value
//   and signed error against the denominator N, so no divider is used.
//   Reset (synchronous, active low) returns the sequencer to idle and drops
//   any partly drawn line. A stalled result holds in the output register and
//   the sequencer waits until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_line_rasterizer_top #(
  parameter int COORD_BITS = hlr_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [hlr_pkg::IN_W-1:0] in_start_q,
  input  wire logic signed [hlr_pkg::IN_W-1:0] in_start_r,
  input  wire logic signed [hlr_pkg::IN_W-1:0] in_end_q,
  input  wire logic signed [hlr_pkg::IN_W-1:0] in_end_r,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [hlr_pkg::OUT_W-1:0]     out_hex_q,
  output logic signed [hlr_pkg::OUT_W-1:0]     out_hex_r,
  output logic        [hlr_pkg::IDX_W-1:0]     out_step_index,
  output logic                                 out_is_last
);

  // coordinates and deltas, s component included
  localparam int DW = COORD_BITS + 2;
  // hex distance, at most 2^(COORD_BITS+1)-2
  localparam int NW = COORD_BITS + 1;
  // rounding error, holds twice the error after one step
  localparam int EW = COORD_BITS + 4;
  // exact numerator coordinate * N
  localparam int XW = 2 * COORD_BITS + 4;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIST = 6'b000010,
    S_INIT = 6'b000100,
    S_STEP = 6'b001000,
    S_FIX  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic        [1:0]      comp_r, comp_nxt;
  logic        [NW-1:0]   i_r, i_nxt;
  logic        [NW-1:0]   n_r, n_nxt;
  logic signed [DW-1:0]   crd_r [3];
  logic signed [DW-1:0]   crd_nxt [3];
  logic signed [DW-1:0]   d_r [3];
  logic signed [DW-1:0]   d_nxt [3];
  logic signed [XW-1:0]   x_r [3];
  logic signed [XW-1:0]   x_nxt [3];
  logic signed [EW-1:0]   e_r [3];
  logic signed [EW-1:0]   e_nxt [3];

  logic signed [hlr_pkg::OUT_W-1:0] hq_r, hq_nxt, hr_r, hr_nxt;
  logic        [NW-1:0]             idx_r, idx_nxt;
  logic                             last_r, last_nxt;

  // sign-extended input coordinates
  logic signed [DW-1:0] aq, ar, bq, br;
  assign aq = DW'($signed(in_start_q[COORD_BITS-1:0]));
  assign ar = DW'($signed(in_start_r[COORD_BITS-1:0]));
  assign bq = DW'($signed(in_end_q[COORD_BITS-1:0]));
  assign br = DW'($signed(in_end_r[COORD_BITS-1:0]));

  // hex distance: largest delta magnitude of the three cube components
  logic [DW-1:0] mag0, mag1, mag2, mag01, span;
  assign mag0  = d_r[0][DW-1] ? DW'(-d_r[0]) : DW'(d_r[0]);
  assign mag1  = d_r[1][DW-1] ? DW'(-d_r[1]) : DW'(d_r[1]);
  assign mag2  = d_r[2][DW-1] ? DW'(-d_r[2]) : DW'(d_r[2]);
  assign mag01 = (mag0 > mag1) ? mag0 : mag1;
  assign span  = (mag01 > mag2) ? mag01 : mag2;

  // operands of the component under work
  logic signed [DW-1:0] cur_crd, cur_d;
  logic signed [XW-1:0] cur_x;
  logic signed [EW-1:0] cur_e, cur_e2, n_s, opnd, sum_e;
  logic signed [XW-1:0] n_x, prod;
  logic                 x_neg, fix_up, fix_dn, fix_any;

  assign cur_crd = crd_r[comp_r];
  assign cur_d   = d_r[comp_r];
  assign cur_x   = x_r[comp_r];
  assign cur_e   = e_r[comp_r];
  assign n_s     = EW'($signed({1'b0, n_r}));
  assign n_x     = XW'($signed({1'b0, n_r}));

  // shared multiplier: start numerator = coordinate * N
  assign prod = XW'(cur_crd) * n_x;

  // rounding check, halves away from zero; a zero-length line is exact
  assign cur_e2  = cur_e <<< 1;
  assign x_neg   = cur_x[XW-1];
  assign fix_up  = x_neg ? (cur_e2 > n_s) : (cur_e2 >= n_s);
  assign fix_dn  = x_neg ? (cur_e2 <= -n_s) : (cur_e2 < -n_s);
  assign fix_any = (fix_up | fix_dn) && (n_r != '0);

  // shared error adder: delta on a step, minus or plus N on a correction
  assign opnd  = (state_r == S_STEP) ? EW'(cur_d) : (fix_up ? -n_s : n_s);
  assign sum_e = cur_e + opnd;

  // pick the component with the largest error and rebuild it
  logic [EW-1:0]        err0, err1, err2;
  logic signed [DW-1:0] sel_q, sel_r;
  assign err0 = e_r[0][EW-1] ? EW'(-e_r[0]) : EW'(e_r[0]);
  assign err1 = e_r[1][EW-1] ? EW'(-e_r[1]) : EW'(e_r[1]);
  assign err2 = e_r[2][EW-1] ? EW'(-e_r[2]) : EW'(e_r[2]);

  always_comb begin
    sel_q = crd_r[0];
    sel_r = crd_r[1];
    if (err0 > err1 && err0 > err2) begin
      sel_q = -crd_r[1] - crd_r[2];
    end else if (err1 > err2) begin
      sel_r = -crd_r[0] - crd_r[2];
    end
  end

  always_comb begin
    state_nxt = state_r;
    comp_nxt  = comp_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    crd_nxt   = crd_r;
    d_nxt     = d_r;
    x_nxt     = x_r;
    e_nxt     = e_r;
    hq_nxt    = hq_r;
    hr_nxt    = hr_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          crd_nxt[0] = aq;
          crd_nxt[1] = ar;
          crd_nxt[2] = -aq - ar;
          d_nxt[0]   = bq - aq;
          d_nxt[1]   = br - ar;
          d_nxt[2]   = (aq + ar) - (bq + br);
          state_nxt  = S_DIST;
        end
      end
      S_DIST: begin
        n_nxt     = NW'(span);
        i_nxt     = '0;
        comp_nxt  = 2'd0;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        x_nxt[comp_r] = prod;
        e_nxt[comp_r] = '0;
        if (comp_r == 2'd2) begin
          // start hex is exact; one check on the last component
          state_nxt = S_FIX;
        end else begin
          comp_nxt = comp_r + 2'd1;
        end
      end
      S_STEP: begin
        x_nxt[comp_r] = cur_x + XW'(cur_d);
        e_nxt[comp_r] = sum_e;
        state_nxt     = S_FIX;
      end
      S_FIX: begin
        if (fix_any) begin
          // move the rounded value one toward the exact point and check again
          e_nxt[comp_r]   = sum_e;
          crd_nxt[comp_r] = fix_up ? cur_crd + DW'(1) : cur_crd - DW'(1);
        end else if (comp_r == 2'd2) begin
          hq_nxt    = hlr_pkg::OUT_W'(sel_q);
          hr_nxt    = hlr_pkg::OUT_W'(sel_r);
          idx_nxt   = i_r;
          last_nxt  = (i_r == n_r);
          state_nxt = S_EMIT;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_STEP;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + NW'(1);
            comp_nxt  = 2'd0;
            state_nxt = S_STEP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      comp_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      comp_r  <= comp_nxt;
    end
  end

  // payload and working registers, no reset needed
  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    n_r    <= n_nxt;
    crd_r  <= crd_nxt;
    d_r    <= d_nxt;
    x_r    <= x_nxt;
    e_r    <= e_nxt;
    hq_r   <= hq_nxt;
    hr_r   <= hr_nxt;
    idx_r  <= idx_nxt;
    last_r <= last_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = (state_r == S_EMIT);
  assign out_hex_q      = hq_r;
  assign out_hex_r      = hr_r;
  assign out_step_index = hlr_pkg::IDX_W'(idx_r);
  assign out_is_last    = last_r;

`ifndef ASSERT_OFF
  // an accepted item starts the distance measurement
  a_accept_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DIST))
    else $error("accepted item did not start distance step");

  // the component index never leaves the three cube components
  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT || state_r == S_STEP || state_r == S_FIX) |-> (comp_r != 2'd3))
    else $error("component index out of range");

  // the step count never passes the distance
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP || state_r == S_FIX || state_r == S_EMIT) |-> (i_r <= n_r))
    else $error("step index beyond distance");

  // taking the last hex frees the input side
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_is_last) |=> !in_stall)
    else $error("block busy after last hex taken");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the hex line rasterizer
// Drives start/end hex pairs, predicts every cube-rounded hex of each line in
// exact rational arithmetic and checks the result stream field by field,
// under random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int IN_W         = hlr_pkg::IN_W;
  localparam int OUT_W        = hlr_pkg::OUT_W;
  localparam int IDX_W        = hlr_pkg::IDX_W;
  localparam int COORD_BITS   = hlr_pkg::COORD_BITS_DEF;
  localparam int RANDOM_ITEMS = 250;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int REPORT_MAX   = 10;

  // one hex of a drawn line, as it appears on the result channel
  typedef struct {
    logic signed [OUT_W-1:0] hex_q;
    logic signed [OUT_W-1:0] hex_r;
    logic        [IDX_W-1:0] step_index;
    logic                    is_last;
  } line_hex_t;

  // Predicts the hexes of each accepted line and matches the block's output.
  class hex_line_board;
    line_hex_t line_hexes[$];
    int        failures = 0;

    function int coord_of(logic [IN_W-1:0] raw);
      int v;
      v = int'(raw) & ((1 << COORD_BITS) - 1);
      if (v >= (1 << (COORD_BITS - 1))) v -= (1 << COORD_BITS);
      return v;
    endfunction

    function int mag(int v);
      return (v < 0) ? -v : v;
    endfunction

    // x/n to nearest, halves away from zero, n > 0
    function int round_half_away(int x, int n);
      if (x >= 0) return (2 * x + n) / (2 * n);
      return -((-2 * x + n) / (2 * n));
    endfunction

    function void note_line(logic [IN_W-1:0] sq_raw, logic [IN_W-1:0] sr_raw,
                            logic [IN_W-1:0] eq_raw, logic [IN_W-1:0] er_raw);
      int aq, ar, dq, dr, span, num_q, num_r, num_s, cq, cr, cs, err_q, err_r, err_s;
      line_hex_t h;
      aq   = coord_of(sq_raw);
      ar   = coord_of(sr_raw);
      dq   = coord_of(eq_raw) - aq;
      dr   = coord_of(er_raw) - ar;
      span = (mag(dq) + mag(dr) + mag(dq + dr)) / 2;
      if (span == 0) begin
        h.hex_q      = aq[OUT_W-1:0];
        h.hex_r      = ar[OUT_W-1:0];
        h.step_index = '0;
        h.is_last    = 1'b1;
        line_hexes.push_back(h);
        return;
      end
      for (int i = 0; i <= span; i++) begin
        num_q = aq * span + dq * i;
        num_r = ar * span + dr * i;
        num_s = -num_q - num_r;
        cq    = round_half_away(num_q, span);
        cr    = round_half_away(num_r, span);
        cs    = round_half_away(num_s, span);
        err_q = mag(cq * span - num_q);
        err_r = mag(cr * span - num_r);
        err_s = mag(cs * span - num_s);
        // rebuild the component that strayed furthest; q wins only strictly
        if (err_q > err_r && err_q > err_s) cq = -cr - cs;
        else if (err_r > err_s)             cr = -cq - cs;
        h.hex_q      = cq[OUT_W-1:0];
        h.hex_r      = cr[OUT_W-1:0];
        h.step_index = i[IDX_W-1:0];
        h.is_last    = (i == span);
        line_hexes.push_back(h);
      end
    endfunction

    function void flag(string what, line_hex_t want, line_hex_t got);
      failures++;
      if (failures <= REPORT_MAX)
        $display("%s: expected q=%0d r=%0d step=%0d last=%0d, %s",
                 what, want.hex_q, want.hex_r, want.step_index, want.is_last,
                 $sformatf("got q=%0d r=%0d step=%0d last=%0d",
                           got.hex_q, got.hex_r, got.step_index, got.is_last));
    endfunction

    function void check_hex(logic signed [OUT_W-1:0] q, logic signed [OUT_W-1:0] r,
                            logic [IDX_W-1:0] idx, logic last);
      line_hex_t got, want;
      got.hex_q      = q;
      got.hex_r      = r;
      got.step_index = idx;
      got.is_last    = last;
      if (line_hexes.size() == 0) begin
        want = '{default: '0};
        flag("unexpected hex", want, got);
        return;
      end
      want = line_hexes.pop_front();
      if (got.hex_q !== want.hex_q || got.hex_r !== want.hex_r ||
          got.step_index !== want.step_index || got.is_last !== want.is_last)
        flag("hex mismatch", want, got);
    endfunction

    function int pending();
      return line_hexes.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [IN_W-1:0]  in_start_q = '0;
  logic signed [IN_W-1:0]  in_start_r = '0;
  logic signed [IN_W-1:0]  in_end_q = '0;
  logic signed [IN_W-1:0]  in_end_r = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_hex_q;
  logic signed [OUT_W-1:0] out_hex_r;
  logic [IDX_W-1:0]        out_step_index;
  logic                    out_is_last;

  hex_line_board board = new();

  // calm: both sides stop idling; hold_req: ask the receiver for one long hold
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  // Directed lines: zero length at the corners, the two longest diagonals both
  // ways, full sweeps along q and r, all six neighbors, and short lines whose
  // midpoint rounds to a tie on q/r, on q/s, on r/s and on the negative side.
  int directed_lines [0:22][0:3] = '{
    '{0, 0, 0, 0},       '{-16, -16, -16, -16}, '{15, 15, 15, 15},
    '{-16, -16, 15, 15}, '{15, 15, -16, -16},   '{-16, 15, 15, -16},
    '{15, -16, -16, 15}, '{0, 0, 1, 1},         '{0, 0, -1, -1},
    '{0, 0, 1, -2},      '{0, 0, -2, 1},        '{3, -2, 4, -2},
    '{3, -2, 4, -3},     '{3, -2, 3, -3},       '{3, -2, 2, -2},
    '{3, -2, 2, -1},     '{3, -2, 3, -1},       '{-16, 0, 15, 0},
    '{0, -16, 0, 15},    '{5, 5, -3, 9},        '{-7, 2, 8, -13},
    '{1, -1, -2, 3},     '{15, -16, -16, -16}
  };

  hex_line_rasterizer_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_q     (in_start_q),
    .in_start_r     (in_start_r),
    .in_end_q       (in_end_q),
    .in_end_r       (in_end_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hex_q      (out_hex_q),
    .out_hex_r      (out_hex_r),
    .out_step_index (out_step_index),
    .out_is_last    (out_is_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: check each hex taken at this edge, then pick the next stall.
  // The long hold is counted here so the sender keeps offering lines while
  // the output register stays full and the block backs up onto its input.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_hex(out_hex_q, out_hex_r, out_step_index, out_is_last);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 26);
    end
  end

  // Offer one line and hold it until taken. Idle cycles drop valid first;
  // once raised, valid and payload stay put through any stall.
  task automatic send_line(input int sq, input int sr, input int eq, input int er);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_q <= sq[IN_W-1:0];
    in_start_r <= sr[IN_W-1:0];
    in_end_q   <= eq[IN_W-1:0];
    in_end_r   <= er[IN_W-1:0];
    do @(posedge clk); while (in_stall);
    board.note_line(in_start_q, in_start_r, in_end_q, in_end_r);
  endtask

  // End point a few hexes away from c, kept inside the coordinate range.
  function automatic int near_coord(int c);
    int v;
    v = c + int'($urandom_range(8)) - 4;
    if (v < -16) v = -16;
    if (v > 15) v = 15;
    return v;
  endfunction

  initial begin
    int sq, sr, eq, er;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k <= 22; k++)
      send_line(directed_lines[k][0], directed_lines[k][1],
                directed_lines[k][2], directed_lines[k][3]);

    // Mostly short lines so the run stays quick; a quarter span the full range
    // and toggle every input bit. One window runs with no idling at all, and
    // the long receiver hold lands later while lines keep coming.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= 80 && k < 130);
      if (k == 170) hold_req = 1'b1;
      sq = int'($urandom_range(31)) - 16;
      sr = int'($urandom_range(31)) - 16;
      if ($urandom_range(99) < 25) begin
        eq = int'($urandom_range(31)) - 16;
        er = int'($urandom_range(31)) - 16;
      end else begin
        eq = near_coord(sq);
        er = near_coord(sr);
      end
      send_line(sq, sr, eq, er);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain every predicted hex, then linger to catch any stray extra output.
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.failures == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
